// ===== design/sfr_pkg.sv =====
`default_nettype none

package sfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgLenW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatBytes = 2'd0,
    CfgPatLen   = 2'd1,
    CfgRepBytes = 2'd2,
    CfgRepLen   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_valid;
    logic             out_last;
  } out_t;

  typedef struct packed {
    logic             accept;
    logic             shift;
    logic [ByteW-1:0] data;
  } win_ctrl_t;

  typedef struct packed {
    logic load;
    logic shift;
  } oq_ctrl_t;

endpackage

`default_nettype wire

// ===== design/stream_find_and_replace.sv =====
// Channel  | Direction | Handshake               | Payload
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// source   | in        | in_valid_i/in_stall_o   | in_data_i (in_byte, in_last)
// edited   | out       | out_valid_o/out_stall_i | out_data_o (out_byte, out_valid, out_last)
//
// A source byte is taken every cycle while at most one result waits in the output queue.
// A matching byte emits r replacement bytes, one per cycle while out_stall_i is low, and an end
// of string flushes up to the pattern length in bytes; the single output port sets this rate.
// The window is a row of MAX_PATTERN byte cells that compare and shift in the cycle of transfer.
// Reset clears config, fill, count and the queue at once but not the window; no clearing pass.
// A stalled output holds its result and the source is stalled once two results wait.
`default_nettype none

module stream_find_and_replace #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sfr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [sfr_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire sfr_pkg::in_t                   in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output sfr_pkg::out_t                       out_data_o
);

  localparam int unsigned MaxRes = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int unsigned QDepth = MaxRes + 1;
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned FillW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [sfr_pkg::CfgDataW-1:0] pat_bytes_q;
  logic [sfr_pkg::CfgLenW-1:0]  pat_len_q;
  logic [sfr_pkg::CfgDataW-1:0] rep_bytes_q;
  logic [sfr_pkg::CfgLenW-1:0]  rep_len_q;
  logic                         cfg_we;
  logic                         pat_len_we;

  logic [FillW-1:0]             fill_q;
  logic [FillW-1:0]             fill_d;
  logic [CntW-1:0]              count_q;
  logic [CntW-1:0]              count_d;

  logic [sfr_pkg::CfgLenW-1:0]  plen;
  logic [sfr_pkg::CfgLenW-1:0]  rlen;
  logic                         plen_nz;
  logic                         accept;
  logic                         last;
  logic                         full;
  logic                         hit;
  logic                         bare;
  logic                         pop;
  logic                         base_one;
  logic [CntW-1:0]              n_raw;
  logic [CntW-1:0]              n_res;
  logic [MAX_PATTERN-1:0]       eq;
  logic [MAX_PATTERN-1:0]       mask;
  logic [sfr_pkg::ByteW-1:0]    eff [MAX_PATTERN];
  sfr_pkg::win_ctrl_t           win_ctrl;
  sfr_pkg::out_t                lst [MaxRes];
  sfr_pkg::out_t                q_entry [QDepth];
  logic [QDepth-1:0]            q_occ;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign pat_len_we  = cfg_we && (sfr_pkg::cfg_reg_e'(cfg_index_i) == sfr_pkg::CfgPatLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_we) begin
      case (sfr_pkg::cfg_reg_e'(cfg_index_i))
        sfr_pkg::CfgPatBytes: pat_bytes_q <= cfg_data_i;
        sfr_pkg::CfgPatLen:   pat_len_q   <= cfg_data_i[sfr_pkg::CfgLenW-1:0];
        sfr_pkg::CfgRepBytes: rep_bytes_q <= cfg_data_i;
        sfr_pkg::CfgRepLen:   rep_len_q   <= cfg_data_i[sfr_pkg::CfgLenW-1:0];
        default: ;
      endcase
    end
  end

  assign plen = (pat_len_q > sfr_pkg::CfgLenW'(MAX_PATTERN)) ?
                sfr_pkg::CfgLenW'(MAX_PATTERN) : pat_len_q;
  assign rlen = (rep_len_q > sfr_pkg::CfgLenW'(MAX_REPLACE)) ?
                sfr_pkg::CfgLenW'(MAX_REPLACE) : rep_len_q;
  assign plen_nz = (plen != '0);

  assign accept = in_valid_i && !in_stall_o;
  assign last   = in_data_i.in_last;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    logic [sfr_pkg::ByteW-1:0] right;
    if (i + 1 < MAX_PATTERN) begin : g_mid
      assign right = eff[i+1];
    end else begin : g_end
      assign right = '0;
    end
    assign mask[i] = (sfr_pkg::CfgLenW'(i) < plen);
    sfr_win_cell #(
      .FillW(FillW),
      .Index(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (win_ctrl),
      .fill_i (fill_q),
      .pat_i  (pat_bytes_q[sfr_pkg::ByteW*i +: sfr_pkg::ByteW]),
      .right_i(right),
      .eff_o  (eff[i]),
      .eq_o   (eq[i])
    );
  end

  assign full = plen_nz && ((sfr_pkg::CfgLenW'(fill_q) + sfr_pkg::CfgLenW'(1)) == plen);
  assign hit  = full && (&(eq | ~mask));

  assign win_ctrl.accept = accept;
  assign win_ctrl.shift  = full && !hit;
  assign win_ctrl.data   = in_data_i.in_byte;

  always_comb begin
    if (!plen_nz) begin
      n_raw = CntW'(1);
    end else if (hit) begin
      n_raw = CntW'(rlen);
    end else if (full) begin
      n_raw = last ? CntW'(plen) : CntW'(1);
    end else begin
      n_raw = last ? (CntW'(fill_q) + CntW'(1)) : '0;
    end
  end

  assign bare  = last && (n_raw == '0);
  assign n_res = bare ? CntW'(1) : n_raw;

  for (genvar k = 0; k < MaxRes; k++) begin : g_lst
    logic [sfr_pkg::ByteW-1:0] rep_b;
    logic [sfr_pkg::ByteW-1:0] win_b;
    if (k < MAX_REPLACE) begin : g_rep
      assign rep_b = rep_bytes_q[sfr_pkg::ByteW*k +: sfr_pkg::ByteW];
    end else begin : g_norep
      assign rep_b = '0;
    end
    if (k < MAX_PATTERN) begin : g_w
      assign win_b = eff[k];
    end else begin : g_now
      assign win_b = '0;
    end
    assign lst[k].out_byte  = bare ? '0 : (hit ? rep_b : win_b);
    assign lst[k].out_valid = !bare;
    assign lst[k].out_last  = last && (CntW'(k + 1) == n_res);
  end

  always_comb begin
    fill_d = fill_q;
    if (pat_len_we) begin
      fill_d = '0;
    end else if (accept) begin
      if (!plen_nz || hit || last) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  assign pop      = q_occ[0] && !out_stall_i;
  assign base_one = !pop && (count_q != '0);

  for (genvar k = 0; k < QDepth; k++) begin : g_oq
    sfr_pkg::out_t     src0;
    sfr_pkg::out_t     src1;
    sfr_pkg::out_t     right;
    logic              right_occ;
    logic              load_here;
    sfr_pkg::oq_ctrl_t ctrl;
    if (k < MaxRes) begin : g_s0
      assign src0 = lst[k];
    end else begin : g_s0z
      assign src0 = '0;
    end
    if (k >= 1) begin : g_s1
      assign src1 = lst[k-1];
      assign load_here = base_one ? (CntW'(k - 1) < n_res) : (CntW'(k) < n_res);
    end else begin : g_s1z
      assign src1 = '0;
      assign load_here = !base_one && (n_res != '0);
    end
    if (k + 1 < QDepth) begin : g_r
      assign right     = q_entry[k+1];
      assign right_occ = q_occ[k+1];
    end else begin : g_rz
      assign right     = '0;
      assign right_occ = 1'b0;
    end
    assign ctrl.load  = accept && load_here;
    assign ctrl.shift = pop;
    sfr_out_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_i     (base_one ? src1 : src0),
      .right_i    (right),
      .right_occ_i(right_occ),
      .entry_o    (q_entry[k]),
      .occ_o      (q_occ[k])
    );
  end

  always_comb begin
    if (accept) begin
      count_d = (base_one ? CntW'(1) : CntW'(0)) + n_res;
    end else begin
      count_d = count_q - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  assign in_stall_o  = (count_q > CntW'(1));
  assign out_valid_o = q_occ[0];
  assign out_data_o  = q_entry[0];

endmodule

`default_nettype wire

// ===== design/sfr_win_cell.sv =====
`default_nettype none

module sfr_win_cell #(
  parameter int unsigned FillW = 3,
  parameter int unsigned Index = 0
) (
  input  wire logic                     clk_i,
  input  wire sfr_pkg::win_ctrl_t       ctrl_i,
  input  wire logic [FillW-1:0]         fill_i,
  input  wire logic [sfr_pkg::ByteW-1:0] pat_i,
  input  wire logic [sfr_pkg::ByteW-1:0] right_i,
  output logic      [sfr_pkg::ByteW-1:0] eff_o,
  output logic                          eq_o
);

  logic [sfr_pkg::ByteW-1:0] byte_q;
  logic [sfr_pkg::ByteW-1:0] byte_d;
  logic                      at_fill;

  assign at_fill = (fill_i == FillW'(Index));
  assign eff_o   = (ctrl_i.accept && at_fill) ? ctrl_i.data : byte_q;
  assign eq_o    = (eff_o == pat_i);
  assign byte_d  = ctrl_i.shift ? right_i : eff_o;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfr_out_cell.sv =====
`default_nettype none

module sfr_out_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfr_pkg::oq_ctrl_t ctrl_i,
  input  wire sfr_pkg::out_t     load_i,
  input  wire sfr_pkg::out_t     right_i,
  input  wire logic              right_occ_i,
  output sfr_pkg::out_t          entry_o,
  output logic                   occ_o
);

  sfr_pkg::out_t entry_q;
  sfr_pkg::out_t entry_d;
  logic          occ_q;
  logic          occ_d;

  always_comb begin
    entry_d = entry_q;
    occ_d   = occ_q;
    if (ctrl_i.load) begin
      entry_d = load_i;
      occ_d   = 1'b1;
    end else if (ctrl_i.shift) begin
      entry_d = right_i;
      occ_d   = right_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.shift) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign occ_o   = occ_q;

endmodule

`default_nettype wire

// ===== design/sfr_checker.sv =====
`default_nettype none

module sfr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire sfr_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sfr_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result changed.");

  a_bare_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_valid |->
      out_data_o.out_last && (out_data_o.out_byte == '0))
    else $error("Result without a byte is not a clean end mark.");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Source stalled with no result waiting.");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.in_last |=> out_valid_o)
    else $error("End of string gave no result.");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== verif/edit_checker.sv =====
module edit_checker
  import sfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o,
  output int unsigned         checked_o,
  output int unsigned         hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CfgDataW-1:0] pat_bytes;
  logic [CfgDataW-1:0] rep_bytes;
  logic [CfgLenW-1:0]  pat_len;
  logic [CfgLenW-1:0]  rep_len;
  logic [ByteW-1:0]    win [8];
  int unsigned         fill;
  out_t                edit_q [$];
  int unsigned         pending = 0;
  int unsigned         errors = 0;
  int unsigned         checked = 0;
  int unsigned         hits = 0;

  assign pending_o = pending;
  assign errors_o  = errors;
  assign checked_o = checked;
  assign hits_o    = hits;

  function automatic int unsigned clip8(logic [CfgLenW-1:0] n);
    return (n > 8) ? 8 : int'(n);
  endfunction

  function automatic void clear_window();
    foreach (win[i]) win[i] = '0;
    fill = 0;
  endfunction

  function automatic logic [ByteW-1:0] pop_oldest();
    logic [ByteW-1:0] b;
    b = win[0];
    for (int i = 0; i < 7; i++) win[i] = win[i + 1];
    win[7] = '0;
    if (fill > 0) fill--;
    return b;
  endfunction

  // Works out every edited result that one source transfer gives rise to.
  function automatic void predict_edit(in_t item);
    out_t        res [8];
    int unsigned n;
    int unsigned plen;
    int unsigned rlen;
    logic        hit;
    n    = 0;
    plen = clip8(pat_len);
    rlen = clip8(rep_len);
    if (plen == 0) begin
      res[n] = '{out_byte: item.in_byte, out_valid: 1'b1, out_last: 1'b0};
      n++;
    end else begin
      if (fill < 8) begin
        win[fill] = item.in_byte;
        fill++;
      end
      if (fill >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++) begin
          if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < rlen; i++) begin
            res[n] = '{out_byte: rep_bytes[8*i +: 8], out_valid: 1'b1, out_last: 1'b0};
            n++;
          end
          clear_window();
          hits++;
        end else begin
          res[n] = '{out_byte: pop_oldest(), out_valid: 1'b1, out_last: 1'b0};
          n++;
        end
      end
    end
    if (item.in_last) begin
      while (fill > 0 && n < 8) begin
        res[n] = '{out_byte: pop_oldest(), out_valid: 1'b1, out_last: 1'b0};
        n++;
      end
      clear_window();
      if (n == 0) begin
        res[n] = '{out_byte: '0, out_valid: 1'b0, out_last: 1'b0};
        n++;
      end
      res[n - 1].out_last = 1'b1;
    end
    for (int i = 0; i < n; i++) edit_q.push_back(res[i]);
  endfunction

  function automatic void note_error(string what, out_t want, out_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected byte %02h valid %0b last %0b, got byte %02h valid %0b last %0b",
               what, want.out_byte, want.out_valid, want.out_last,
               got.out_byte, got.out_valid, got.out_last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      pat_bytes = '0;
      rep_bytes = '0;
      pat_len   = '0;
      rep_len   = '0;
      clear_window();
      edit_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgPatBytes: pat_bytes = cfg_data_i;
          CfgPatLen: begin
            pat_len = cfg_data_i[CfgLenW-1:0];
            clear_window();
          end
          CfgRepBytes: rep_bytes = cfg_data_i;
          CfgRepLen:   rep_len = cfg_data_i[CfgLenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_edit(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (edit_q.size() == 0) begin
          note_error("Unexpected transfer", '0, out_data_i);
        end else begin
          want = edit_q.pop_front();
          checked++;
          if (out_data_i.out_byte != want.out_byte || out_data_i.out_valid != want.out_valid ||
              out_data_i.out_last != want.out_last) begin
            note_error("Mismatch", want, out_data_i);
          end
        end
      end
    end
    pending = edit_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_reg_e            cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;

  int unsigned         pending;
  int unsigned         errors;
  int unsigned         checked;
  int unsigned         hits;

  int unsigned         tx_idle_pct = 0;
  int unsigned         rx_idle_pct = 0;
  bit                  long_hold = 1'b0;
  logic [CfgDataW-1:0] cur_pat = '0;
  int unsigned         cur_plen = 0;
  logic [ByteW-1:0]    text_q [$];
  int unsigned         bytes_sent = 0;
  int unsigned         strings_sent = 0;

  stream_find_and_replace dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  edit_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .pending_o  (pending),
    .errors_o   (errors),
    .checked_o  (checked),
    .hits_o     (hits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The long hold-off lets the block fill up while the sender keeps offering transfers.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (100) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_config(logic [CfgDataW-1:0] pb, logic [CfgLenW-1:0] pl,
                             logic [CfgDataW-1:0] rb, logic [CfgLenW-1:0] rl);
    logic [CfgDataW-1:0] noise;
    noise = {$urandom, $urandom};
    write_reg(CfgPatBytes, pb);
    write_reg(CfgPatLen, {noise[CfgDataW-1:CfgLenW], pl});
    write_reg(CfgRepBytes, rb);
    write_reg(CfgRepLen, {noise[CfgDataW-1:CfgLenW], rl});
    cfg_valid <= 1'b0;
    cur_pat  = pb;
    cur_plen = (pl > 8) ? 8 : int'(pl);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_byte(logic [ByteW-1:0] b, bit last);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_text(bit close);
    foreach (text_q[i]) send_byte(text_q[i], close && (i == text_q.size() - 1));
  endtask

  // Half whole occurrences of the pattern, mixed with broken prefixes and stray bytes.
  task automatic gen_text(int unsigned chunks);
    int unsigned kind;
    int unsigned n;
    text_q.delete();
    repeat (chunks) begin
      kind = $urandom_range(0, 9);
      if (cur_plen != 0 && kind < 5) begin
        for (int i = 0; i < cur_plen; i++) text_q.push_back(cur_pat[8*i +: 8]);
      end else if (cur_plen != 0 && kind < 7) begin
        n = $urandom_range(1, cur_plen);
        for (int i = 0; i < n; i++) text_q.push_back(cur_pat[8*i +: 8]);
        text_q.push_back(ByteW'($urandom_range(0, 255)));
      end else if (cur_plen != 0 && kind < 8) begin
        n = $urandom_range(0, cur_plen - 1);
        text_q.push_back(cur_pat[8*n +: 8]);
      end else begin
        text_q.push_back(ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [CfgLenW-1:0] plen;
    int unsigned        goal;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgPatBytes;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idle_pct = 20;
    rx_idle_pct = 73;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_config(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    text_q = '{8'h78, 8'h61, 8'h62, 8'h79};
    send_text(1'b1);
    text_q = '{8'hFF};
    send_text(1'b1);
    text_q = '{8'h00, 8'h61, 8'h61, 8'h62};
    send_text(1'b1);

    // A rewrite of the pattern length must forget the held partial match.
    text_q = '{8'h61};
    send_text(1'b0);
    wait_drained();
    load_config(64'h6261, 4'd2, 64'h5A5958, 4'd0);
    text_q = '{8'h62};
    send_text(1'b1);
    text_q = '{8'h61, 8'h62};
    send_text(1'b1);
    text_q = '{8'h61, 8'h62, 8'h63};
    send_text(1'b1);

    wait_drained();
    load_config(64'h6261, 4'd0, 64'h5A5958, 4'd3);
    text_q = '{8'h71};
    send_text(1'b1);

    wait_drained();
    load_config('1, 4'd15, '0, 4'd15);
    text_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(1'b1);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 73 : 0;
      rx_idle_pct = (p < 2) ? 73 : (p < 4) ? 20 : 0;
      case (p)
        0:       plen = CfgLenW'($urandom_range(1, 2));
        1:       plen = CfgLenW'($urandom_range(3, 5));
        2:       plen = CfgLenW'($urandom_range(6, 8));
        3:       plen = '0;
        4:       plen = CfgLenW'($urandom_range(1, 3));
        default: plen = CfgLenW'($urandom_range(9, 15));
      endcase
      if (p == 4) begin
        load_config('0, plen, '1, CfgLenW'($urandom_range(0, 15)));
        long_hold = 1'b1;
      end else begin
        load_config({$urandom, $urandom}, plen, {$urandom, $urandom},
                    CfgLenW'($urandom_range(0, 15)));
      end
      goal = bytes_sent + 50;
      while (bytes_sent < goal) begin
        gen_text($urandom_range(1, 5));
        send_text(1'b1);
      end
    end
    wait_drained();

    $display("Sent %0d source bytes in %0d strings under ten register settings.",
             bytes_sent, strings_sent);
    $display("Checked %0d edited results, %0d of the replacements included.", checked, hits);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sfr_pkg.sv
design/sfr_win_cell.sv
design/sfr_out_cell.sv
design/stream_find_and_replace.sv
design/sfr_checker.sv
verif/edit_checker.sv
verif/tb_top.sv
